[rtl/core/spc_pkg.sv]
// ============================================================================
// spc_pkg
// Shared constants and types for the sphere versus bounded plane test.
// ============================================================================
package spc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int UNIT_BITS     = 28;

    // register indexes (byte address is 8 * index)
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_ROTATION = 3'd3;
    localparam logic [2:0] REG_U_AXIS   = 3'd4;
    localparam logic [2:0] REG_V_AXIS   = 3'd5;
    localparam logic [2:0] REG_SIZE     = 3'd6;
    localparam logic [2:0] REG_SCALE    = 3'd7;

    // register reset values
    localparam logic [63:0] ROTATION_RST = 64'd16384;
    localparam logic [47:0] U_AXIS_RST   = 48'd16384;
    localparam logic [47:0] V_AXIS_RST   = 48'd1073741824;
    localparam logic [30:0] SIZE_RST     = 31'd65536;
    localparam logic [63:0] SCALE_RST    = 64'd281479271743488;

    // unit vector component, Q28 with sign
    typedef logic signed [29:0] unit_t;
    typedef unit_t [2:0] unit_vec_t;

endpackage

[rtl/core/sphere_plane_collision_test.sv]
// ============================================================================
// sphere_plane_collision_test
// Tests a stream of spheres against one bounded plane held in registers.
// ============================================================================
// Usage:
//   Configuration goes in over the APB port (64-bit data, register i at
//   byte address 8*i). Sphere beats enter on s_*, one result beat per sphere
//   leaves on m_* in the same order.
//   After reset and after every register write a basis sequencer rebuilds
//   the plane's unit U, V and normal vectors: it builds the rotation matrix,
//   then per vector runs a rotate or cross step and a shared unitize unit
//   (up to 28 shift steps and a final check, 3 square steps, 32 square-root
//   steps and 3 x 58 divide steps). s_tready stays low meanwhile; register
//   writes are taken as ever.
//   Once the basis is ready the datapath takes one sphere per cycle while
//   no stall on m_tready has filled its stages. It has four register stages
//   (offset/sizes, projection products, sums and compares, contact point
//   into the output register); the first stage loads on the accepting edge
//   and m_tvalid is the valid flag of the fourth stage.
//   Each stage holds its beat while the next stage is full and held; a stall on
//   m_tready backs up stage by stage without losing or repeating a beat,
//   and empty stages keep taking new beats.
// ============================================================================
module sphere_plane_collision_test
#(
    parameter int FRAC_BITS = spc_pkg::FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // sphere_x[31:0], sphere_y[63:32], sphere_z[95:64], sphere_radius[126:96],
    // sphere_scale[157:127], zero pad [159:158]
    input  logic [159:0] s_tdata,
    // sphere_dynamic[0], plane_dynamic[1]
    input  logic [1:0]   s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hit_x[31:0], hit_y[63:32], hit_z[95:64], normal_x[113:96],
    // normal_y[131:114], normal_z[149:132], zero pad [151:150]
    output logic [151:0] m_tdata,
    // collided[0], update_sphere[1], update_plane[2]
    output logic [2:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import spc_pkg::*;

    localparam int DOWN = UNIT_BITS - FRAC_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAT   = 3'd1;
    localparam logic [2:0] ST_ROT   = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_SQ    = 3'd4;
    localparam logic [2:0] ST_SQRT  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_CROSS = 3'd7;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [63:0] rotation_reg;
    logic [47:0] u_axis_reg, v_axis_reg;
    logic [30:0] size_reg;
    logic [63:0] scale_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            rotation_reg <= ROTATION_RST;
            u_axis_reg   <= U_AXIS_RST;
            v_axis_reg   <= V_AXIS_RST;
            size_reg     <= SIZE_RST;
            scale_reg    <= SCALE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ORIGIN_X: origin_x_reg <= pwdata[31:0];
                REG_ORIGIN_Y: origin_y_reg <= pwdata[31:0];
                REG_ORIGIN_Z: origin_z_reg <= pwdata[31:0];
                REG_ROTATION: rotation_reg <= pwdata;
                REG_U_AXIS:   u_axis_reg   <= pwdata[47:0];
                REG_V_AXIS:   v_axis_reg   <= pwdata[47:0];
                REG_SIZE:     size_reg     <= pwdata[30:0];
                REG_SCALE:    scale_reg    <= pwdata;
                default:      ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_ORIGIN_X: prdata = {32'd0, origin_x_reg};
            REG_ORIGIN_Y: prdata = {32'd0, origin_y_reg};
            REG_ORIGIN_Z: prdata = {32'd0, origin_z_reg};
            REG_ROTATION: prdata = rotation_reg;
            REG_U_AXIS:   prdata = {16'd0, u_axis_reg};
            REG_V_AXIS:   prdata = {16'd0, v_axis_reg};
            REG_SIZE:     prdata = {33'd0, size_reg};
            REG_SCALE:    prdata = scale_reg;
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // basis sequencer: rotate, cross and unitize
    // ------------------------------------------------------------------
    logic [2:0]  state_reg;
    logic [1:0]  sel_reg;            // 0: U, 1: V, 2: normal
    logic [1:0]  k_reg;
    logic [5:0]  cnt_reg;
    logic signed [35:0] mat_reg [3][3];
    logic [63:0] un_m_reg [3];
    logic [63:0] un_mx_reg;
    logic [2:0]  un_neg_reg;
    logic [63:0] len2_reg;
    logic [63:0] sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [31:0] rem_reg;
    logic [57:0] dvd_reg;
    unit_vec_t   q_reg;
    unit_vec_t   u_reg, v_reg, n_reg;

    logic signed [15:0] qx, qy, qz, qw;
    logic signed [15:0] ax [3];
    logic signed [35:0] mat_next [3][3];
    logic signed [63:0] rot_c [3];
    logic signed [63:0] crs_c [3];
    logic signed [63:0] load_c [3];
    logic [63:0] load_m [3];
    logic [63:0] load_mx;
    logic [63:0] sq_try;
    logic [32:0] rem_try;
    logic        q_bit;
    logic [59:0] m_sq;
    unit_vec_t   q_fin;

    assign qx = $signed(rotation_reg[15:0]);
    assign qy = $signed(rotation_reg[31:16]);
    assign qz = $signed(rotation_reg[47:32]);
    assign qw = $signed(rotation_reg[63:48]);

    // rotation matrix from the quaternion
    always_comb
    begin
        logic signed [35:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
        xx = 36'(qx * qx);  yy = 36'(qy * qy);  zz = 36'(qz * qz);
        ww = 36'(qw * qw);  xy = 36'(qx * qy);  xz = 36'(qx * qz);
        yz = 36'(qy * qz);  wx = 36'(qw * qx);  wy = 36'(qw * qy);
        wz = 36'(qw * qz);
        mat_next[0][0] = xx + ww - yy - zz;
        mat_next[0][1] = 2 * xy - 2 * wz;
        mat_next[0][2] = 2 * xz + 2 * wy;
        mat_next[1][0] = 2 * wz + 2 * xy;
        mat_next[1][1] = ww - xx + yy - zz;
        mat_next[1][2] = 2 * yz - 2 * wx;
        mat_next[2][0] = 2 * xz - 2 * wy;
        mat_next[2][1] = 2 * wx + 2 * yz;
        mat_next[2][2] = ww - xx - yy + zz;
    end

    // rotate the selected axis, or cross U with V
    always_comb
    begin
        logic [47:0] axis;
        axis = (sel_reg == 2'd0) ? u_axis_reg : v_axis_reg;
        for (int i = 0; i < 3; i++)
        begin
            ax[i] = $signed(axis[16*i +: 16]);
        end
        for (int i = 0; i < 3; i++)
        begin
            rot_c[i] = 64'(mat_reg[i][0] * ax[0]) + 64'(mat_reg[i][1] * ax[1])
                     + 64'(mat_reg[i][2] * ax[2]);
        end
        crs_c[0] = 64'(u_reg[1] * v_reg[2]) - 64'(u_reg[2] * v_reg[1]);
        crs_c[1] = 64'(u_reg[2] * v_reg[0]) - 64'(u_reg[0] * v_reg[2]);
        crs_c[2] = 64'(u_reg[0] * v_reg[1]) - 64'(u_reg[1] * v_reg[0]);
        load_mx = '0;
        for (int i = 0; i < 3; i++)
        begin
            load_c[i] = (state_reg == ST_CROSS) ? crs_c[i] : rot_c[i];
            load_m[i] = load_c[i][63] ? 64'(-load_c[i]) : 64'(load_c[i]);
            if (load_m[i] > load_mx)
            begin
                load_mx = load_m[i];
            end
        end
    end

    // one step of each iterative unit
    assign m_sq    = un_m_reg[k_reg][29:0] * un_m_reg[k_reg][29:0];
    assign sq_try  = sq_r_reg + sq_bit_reg;
    assign rem_try = {rem_reg, dvd_reg[57]};
    assign q_bit   = (rem_try >= {1'b0, sq_r_reg[31:0]});

    always_comb
    begin
        unit_t qv;
        q_fin = q_reg;
        qv = (sq_r_reg == '0) ? unit_t'(0)
                              : unit_t'({1'b0, dvd_reg[27:0], q_bit});
        q_fin[k_reg] = un_neg_reg[k_reg] ? -qv : qv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MAT;
            sel_reg   <= 2'd0;
            k_reg     <= 2'd0;
            cnt_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            // rebuild the basis after any write
            state_reg <= ST_MAT;
            sel_reg   <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_MAT:
                begin
                    state_reg <= ST_ROT;
                end
                ST_ROT, ST_CROSS:
                begin
                    state_reg <= ST_SHIFT;
                end
                ST_SHIFT:
                begin
                    if (un_mx_reg[63:30] == '0)
                    begin
                        state_reg <= ST_SQ;
                        k_reg     <= 2'd0;
                    end
                end
                ST_SQ:
                begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= ST_SQRT;
                        cnt_reg   <= 6'd32;
                    end
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= ST_DIV;
                        k_reg     <= 2'd0;
                        cnt_reg   <= 6'd58;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        cnt_reg <= 6'd58;
                        k_reg   <= k_reg + 2'd1;
                        if (k_reg == 2'd2)
                        begin
                            sel_reg <= sel_reg + 2'd1;
                            priority if (sel_reg == 2'd0)
                                state_reg <= ST_ROT;
                            else if (sel_reg == 2'd1)
                                state_reg <= ST_CROSS;
                            else
                                state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath of the sequencer
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE: ;
            ST_MAT:
            begin
                mat_reg <= mat_next;
            end
            ST_ROT, ST_CROSS:
            begin
                un_m_reg  <= load_m;
                un_mx_reg <= load_mx;
                for (int i = 0; i < 3; i++)
                begin
                    un_neg_reg[i] <= load_c[i][63];
                end
                len2_reg <= '0;
            end
            ST_SHIFT:
            begin
                // scale down until the largest magnitude fits in 30 bits
                if (un_mx_reg[63:30] != '0)
                begin
                    un_mx_reg <= un_mx_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        un_m_reg[i] <= un_m_reg[i] >> 1;
                    end
                end
            end
            ST_SQ:
            begin
                if (k_reg == 2'd2)
                begin
                    sq_n_reg   <= len2_reg + 64'(m_sq);
                    sq_r_reg   <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                end
                len2_reg <= len2_reg + 64'(m_sq);
            end
            ST_SQRT:
            begin
                if (sq_n_reg >= sq_try)
                begin
                    sq_n_reg <= sq_n_reg - sq_try;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                if (cnt_reg == 6'd1)
                begin
                    rem_reg <= '0;
                    dvd_reg <= {un_m_reg[0][29:0], 28'd0};
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                rem_reg <= q_bit ? 32'(rem_try - {1'b0, sq_r_reg[31:0]})
                                 : rem_try[31:0];
                dvd_reg <= {dvd_reg[56:0], q_bit};
                if (cnt_reg == 6'd1)
                begin
                    q_reg   <= q_fin;
                    rem_reg <= '0;
                    if (k_reg != 2'd2)
                    begin
                        dvd_reg <= {un_m_reg[k_reg + 2'd1][29:0], 28'd0};
                    end
                    if (k_reg == 2'd2)
                    begin
                        priority if (sel_reg == 2'd0)
                            u_reg <= q_fin;
                        else if (sel_reg == 2'd1)
                            v_reg <= q_fin;
                        else
                            n_reg <= q_fin;
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // sphere pipeline
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1 && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid && s_tready;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: center offset and bounds
    logic signed [31:0] s1_s_reg [3];
    logic signed [32:0] s1_d_reg [3];
    logic signed [63:0] s1_usize_reg, s1_vsize_reg;
    logic [61:0] s1_rad_reg;
    logic [1:0]  s1_dyn_reg;
    logic signed [31:0] in_s [3];
    logic signed [31:0] org [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_s[i] = $signed(s_tdata[32*i +: 32]);
        end
        org[0] = $signed(origin_x_reg);
        org[1] = $signed(origin_y_reg);
        org[2] = $signed(origin_z_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_s_reg[i] <= in_s[i];
                s1_d_reg[i] <= 33'(in_s[i]) - 33'(org[i]);
            end
            s1_usize_reg <= $signed({1'b0, size_reg}) * $signed(scale_reg[31:0]);
            s1_vsize_reg <= $signed({1'b0, size_reg}) * $signed(scale_reg[63:32]);
            s1_rad_reg   <= s_tdata[126:96] * s_tdata[157:127];
            s1_dyn_reg   <= s_tuser;
        end
    end

    // stage 2: projection products
    logic signed [62:0] s2_pu_reg [3], s2_pv_reg [3], s2_pn_reg [3];
    logic signed [31:0] s2_s_reg [3];
    logic signed [63:0] s2_usize_reg, s2_vsize_reg;
    logic [61:0] s2_rad_reg;
    logic [1:0]  s2_dyn_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_pu_reg[i] <= s1_d_reg[i] * u_reg[i];
                s2_pv_reg[i] <= s1_d_reg[i] * v_reg[i];
                s2_pn_reg[i] <= s1_d_reg[i] * n_reg[i];
            end
            s2_s_reg     <= s1_s_reg;
            s2_usize_reg <= s1_usize_reg;
            s2_vsize_reg <= s1_vsize_reg;
            s2_rad_reg   <= s1_rad_reg;
            s2_dyn_reg   <= s1_dyn_reg;
        end
    end

    // stage 3: sums, shifts and bound compares
    logic signed [65:0] dot_u, dot_v, dot_n, pu, pv, pn;
    logic [65:0] pn_abs;
    logic        hit;
    logic        s3_hit_reg, s3_neg_reg, s3_zero_reg;
    logic signed [37:0] s3_npf_reg;
    logic signed [31:0] s3_s_reg [3];
    logic [1:0]  s3_dyn_reg;

    always_comb
    begin
        dot_u  = 66'(s2_pu_reg[0]) + 66'(s2_pu_reg[1]) + 66'(s2_pu_reg[2]);
        dot_v  = 66'(s2_pv_reg[0]) + 66'(s2_pv_reg[1]) + 66'(s2_pv_reg[2]);
        dot_n  = 66'(s2_pn_reg[0]) + 66'(s2_pn_reg[1]) + 66'(s2_pn_reg[2]);
        pu     = dot_u >>> DOWN;
        pv     = dot_v >>> DOWN;
        pn     = dot_n >>> DOWN;
        pn_abs = pn[65] ? 66'(-pn) : 66'(pn);
        hit    = (pu <= 66'(s2_usize_reg)) && (pv <= 66'(s2_vsize_reg))
              && (pn_abs <= 66'(s2_rad_reg));
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_hit_reg  <= hit;
            s3_neg_reg  <= pn[65];
            s3_zero_reg <= (pn == '0);
            s3_npf_reg  <= 38'(dot_n >>> UNIT_BITS);
            s3_s_reg    <= s2_s_reg;
            s3_dyn_reg  <= s2_dyn_reg;
        end
    end

    // stage 4: contact point and normal into the output register
    logic [31:0] hit_next [3];
    logic [17:0] nrm_next [3];
    logic [95:0]  out_hit_reg;
    logic [53:0]  out_nrm_reg;
    logic [2:0]   out_flag_reg;

    always_comb
    begin
        logic signed [67:0] prod;
        logic signed [29:0] nq;
        for (int i = 0; i < 3; i++)
        begin
            prod = n_reg[i] * s3_npf_reg;
            hit_next[i] = 32'(s3_s_reg[i]) - 32'(prod >>> UNIT_BITS);
            nq = n_reg[i] >>> DOWN;
            if (s3_neg_reg)
                nq = -nq;
            else if (s3_zero_reg)
                nq = '0;
            nrm_next[i] = nq[17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            if (s3_hit_reg)
            begin
                out_hit_reg  <= {hit_next[2], hit_next[1], hit_next[0]};
                out_nrm_reg  <= {nrm_next[2], nrm_next[1], nrm_next[0]};
                out_flag_reg <= {s3_dyn_reg[1], s3_dyn_reg[0], 1'b1};
            end
            else
            begin
                out_hit_reg  <= '0;
                out_nrm_reg  <= '0;
                out_flag_reg <= '0;
            end
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {2'b00, out_nrm_reg, out_hit_reg};
    assign m_tuser  = out_flag_reg;

endmodule

[rtl/core/spc_checker.sv]
// ============================================================================
// spc_checker
// Port-level checks on the collision test, bound to the top level.
// ============================================================================
module spc_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic [151:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         pready
);

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // a miss carries all zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && m_tuser == '0)
        else $error("miss with nonzero fields");

    // update flags only with a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1] || m_tuser[2]) |-> m_tuser[0])
        else $error("update flag without hit");

    // configuration port never waits
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind sphere_plane_collision_test spc_checker u_spc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .pready   (pready)
);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the sphere versus bounded plane collision block.
// Drives sphere beats through directed cases, degenerate planes and random
// phases under several plane settings, predicts each contact in the bench
// and checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

    import spc_pkg::*;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        radius;
        logic [30:0]        scale;
        logic               sphere_dyn;
        logic               plane_dyn;
    } sphere_t;

    typedef struct {
        logic        collided;
        logic [31:0] hit_x;
        logic [31:0] hit_y;
        logic [31:0] hit_z;
        logic [17:0] normal_x;
        logic [17:0] normal_y;
        logic [17:0] normal_z;
        logic        update_sphere;
        logic        update_plane;
    } contact_t;

    logic         clk;
    logic         rst_n;
    logic [159:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    // plane registers as the bench sees them
    logic [31:0] origin_x_r;
    logic [31:0] origin_y_r;
    logic [31:0] origin_z_r;
    logic [63:0] rotation_r;
    logic [47:0] u_axis_r;
    logic [47:0] v_axis_r;
    logic [30:0] size_r;
    logic [63:0] scale_r;

    contact_t contact_q[$];
    int       error_count;
    int       send_idle_pct;
    int       recv_stall_pct;

    sphere_plane_collision_test DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // contact predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic vec3_t unitize(vec3_t c);
        longint unsigned m [3];
        longint unsigned mx;
        longint unsigned len2;
        longint unsigned len;
        int              sh;
        longint          q;
        vec3_t           o;
        mx = 0;
        len2 = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
            if (m[i] > mx)
                mx = m[i];
        end
        while ((mx >> sh) >= (64'd1 << 30))
            sh++;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = m[i] >> sh;
            len2 += m[i] * m[i];
        end
        len = isqrt(len2);
        for (int i = 0; i < 3; i++)
        begin
            q = (len != 0) ? longint'((m[i] << UNIT_BITS) / len) : 0;
            o[i] = (c[i] < 0) ? -q : q;
        end
        return o;
    endfunction

    function automatic vec3_t rotate_axis(logic [47:0] ax);
        longint qx, qy, qz, qw, vx, vy, vz;
        vec3_t  r;
        qx = longint'($signed(rotation_r[15:0]));
        qy = longint'($signed(rotation_r[31:16]));
        qz = longint'($signed(rotation_r[47:32]));
        qw = longint'($signed(rotation_r[63:48]));
        vx = longint'($signed(ax[15:0]));
        vy = longint'($signed(ax[31:16]));
        vz = longint'($signed(ax[47:32]));
        r[0] = vx * (qx*qx + qw*qw - qy*qy - qz*qz) + vy * (2*qx*qy - 2*qw*qz)
             + vz * (2*qx*qz + 2*qw*qy);
        r[1] = vx * (2*qw*qz + 2*qx*qy) + vy * (qw*qw - qx*qx + qy*qy - qz*qz)
             + vz * (2*qy*qz - 2*qw*qx);
        r[2] = vx * (2*qx*qz - 2*qw*qy) + vy * (2*qw*qx + 2*qy*qz)
             + vz * (qw*qw - qx*qx - qy*qy + qz*qz);
        return unitize(r);
    endfunction

    function automatic contact_t predict_contact(sphere_t sp);
        localparam int DOWN = UNIT_BITS - FRAC_BITS_DEF;
        vec3_t           u, v, n, c, d, s;
        longint          pu, pv, pn, pnabs, npf, usz, vsz, off, nq, dn;
        longint unsigned rad;
        logic [63:0]     hit_w;
        logic [63:0]     nq_w;
        contact_t        r;
        u = rotate_axis(u_axis_r);
        v = rotate_axis(v_axis_r);
        c[0] = u[1] * v[2] - u[2] * v[1];
        c[1] = u[2] * v[0] - u[0] * v[2];
        c[2] = u[0] * v[1] - u[1] * v[0];
        n = unitize(c);
        s[0] = longint'(sp.x);
        s[1] = longint'(sp.y);
        s[2] = longint'(sp.z);
        d[0] = s[0] - longint'($signed(origin_x_r));
        d[1] = s[1] - longint'($signed(origin_y_r));
        d[2] = s[2] - longint'($signed(origin_z_r));
        usz = longint'(size_r) * longint'($signed(scale_r[31:0]));
        vsz = longint'(size_r) * longint'($signed(scale_r[63:32]));
        rad = longint'(sp.radius) * longint'(sp.scale);
        dn = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        pu = (d[0] * u[0] + d[1] * u[1] + d[2] * u[2]) >>> DOWN;
        pv = (d[0] * v[0] + d[1] * v[1] + d[2] * v[2]) >>> DOWN;
        pn = dn >>> DOWN;
        pnabs = (pn < 0) ? -pn : pn;
        r = '{default: '0};
        if (pu <= usz && pv <= vsz && $unsigned(pnabs) <= rad)
        begin
            r.collided = 1'b1;
            npf = dn >>> UNIT_BITS;
            for (int i = 0; i < 3; i++)
            begin
                off = (n[i] * npf) >>> UNIT_BITS;
                nq = n[i] >>> DOWN;
                if (pn < 0)
                    nq = -nq;
                else if (pn == 0)
                    nq = 0;
                hit_w = s[i] - off;
                nq_w = nq;
                case (i)
                    0:
                    begin
                        r.hit_x = hit_w[31:0];
                        r.normal_x = nq_w[17:0];
                    end
                    1:
                    begin
                        r.hit_y = hit_w[31:0];
                        r.normal_y = nq_w[17:0];
                    end
                    default:
                    begin
                        r.hit_z = hit_w[31:0];
                        r.normal_z = nq_w[17:0];
                    end
                endcase
            end
            r.update_sphere = sp.sphere_dyn;
            r.update_plane = sp.plane_dyn;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ORIGIN_X: origin_x_r = value[31:0];
            REG_ORIGIN_Y: origin_y_r = value[31:0];
            REG_ORIGIN_Z: origin_z_r = value[31:0];
            REG_ROTATION: rotation_r = value;
            REG_U_AXIS:   u_axis_r = value[47:0];
            REG_V_AXIS:   v_axis_r = value[47:0];
            REG_SIZE:     size_r = value[30:0];
            default:      scale_r = value;
        endcase
    endtask

    task automatic set_plane(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [63:0] rot,
                             input logic [47:0] ua, input logic [47:0] va,
                             input logic [30:0] sz, input logic [63:0] sc);
        // drop the stream, then hold off until the previous phase has drained
        s_tvalid <= 1'b0;
        wait (contact_q.size() == 0);
        write_reg(REG_ORIGIN_X, {32'd0, ox});
        write_reg(REG_ORIGIN_Y, {32'd0, oy});
        write_reg(REG_ORIGIN_Z, {32'd0, oz});
        write_reg(REG_ROTATION, rot);
        write_reg(REG_U_AXIS, {16'd0, ua});
        write_reg(REG_V_AXIS, {16'd0, va});
        write_reg(REG_SIZE, {33'd0, sz});
        write_reg(REG_SCALE, sc);
    endtask

    // valid stays high after the beat so the next send can follow with no gap
    task automatic send_sphere(input sphere_t sp);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata <= {2'b00, sp.scale, sp.radius, sp.z, sp.y, sp.x};
        s_tuser <= {sp.plane_dyn, sp.sphere_dyn};
        s_tvalid <= 1'b1;
        // beat moves at the edge after a negedge that sees tready high
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        contact_q.push_back(predict_contact(sp));
    endtask

    // stall the result side at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        contact_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (contact_q.size() == 0)
            begin
                $error("result beat with no contact pending");
                error_count++;
            end
            else
            begin
                e = contact_q.pop_front();
                check_field("collided", e.collided, m_tuser[0]);
                check_field("update_sphere", e.update_sphere, m_tuser[1]);
                check_field("update_plane", e.update_plane, m_tuser[2]);
                check_field("hit_x", e.hit_x, m_tdata[31:0]);
                check_field("hit_y", e.hit_y, m_tdata[63:32]);
                check_field("hit_z", e.hit_z, m_tdata[95:64]);
                check_field("normal_x", e.normal_x, m_tdata[113:96]);
                check_field("normal_y", e.normal_y, m_tdata[131:114]);
                check_field("normal_z", e.normal_z, m_tdata[149:132]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic sphere_t make_sphere(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z, input logic [30:0] rad,
                                            input logic [30:0] sc, input logic [1:0] dyn);
        sphere_t sp;
        sp.x = x;
        sp.y = y;
        sp.z = z;
        sp.radius = rad;
        sp.scale = sc;
        sp.sphere_dyn = dyn[0];
        sp.plane_dyn = dyn[1];
        return sp;
    endfunction

    function automatic logic [31:0] near_coord(input logic [31:0] base);
        int span;
        span = 1 << $urandom_range(8, 20);
        return base + $urandom_range(2 * span) - span;
    endfunction

    function automatic sphere_t random_sphere();
        if ($urandom_range(99) < 25)
            return make_sphere($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom);
        return make_sphere(near_coord(origin_x_r), near_coord(origin_y_r),
                           near_coord(origin_z_r), $urandom_range(0, 1 << 19),
                           $urandom_range(1 << 14, 1 << 17), $urandom);
    endfunction

    function automatic logic [15:0] rand_q14();
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    task automatic random_plane();
        set_plane(32'($urandom_range(0, 1 << 21) - (1 << 20)),
                  32'($urandom_range(0, 1 << 21) - (1 << 20)),
                  32'($urandom_range(0, 1 << 21) - (1 << 20)),
                  {rand_q14(), rand_q14(), rand_q14(), rand_q14()},
                  {rand_q14(), rand_q14(), rand_q14()},
                  {rand_q14(), rand_q14(), rand_q14()},
                  $urandom_range(1 << 14, 1 << 19),
                  {32'($urandom_range(1 << 15, 1 << 17)),
                   32'($urandom_range(1 << 15, 1 << 17))});
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_plane();
        // reset plane: U = +x, V = -y, normal = -z, extent one unit
        send_sphere(make_sphere(0, 0, 0, 0, 0, 2'b00));
        send_sphere(make_sphere(0, 0, 32'h0000_8000, 31'h8000, 31'h10000, 2'b01));
        send_sphere(make_sphere(0, 0, 32'hFFFF_8000, 31'h8000, 31'h10000, 2'b10));
        send_sphere(make_sphere(32'h0001_0000, 32'hFFFF_0000, 0, 31'h1, 31'h1, 2'b11));
        send_sphere(make_sphere(32'h0001_0001, 0, 0, 31'h10000, 31'h10000, 2'b11));
        send_sphere(make_sphere(32'h8000_0000, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF,
                                31'h7FFF_FFFF, 2'b11));
        send_sphere(make_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                31'h7FFF_FFFF, 31'h7FFF_FFFF, 2'b01));
        send_sphere(make_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                31'h7FFF_FFFF, 31'h7FFF_FFFF, 2'b10));
        send_sphere(make_sphere(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                31'h7FFF_FFFF, 31'h0, 2'b11));
        send_sphere(make_sphere(0, 0, 32'h0010_0000, 31'h1_0000, 31'h1_0000, 2'b11));
    endtask

    task automatic test_degenerate_planes();
        // zero U axis: U projection vanishes
        set_plane(0, 0, 0, ROTATION_RST, 48'd0, V_AXIS_RST, SIZE_RST, SCALE_RST);
        send_sphere(make_sphere(32'h0100_0000, 0, 32'h0000_4000, 31'h8000, 31'h10000,
                                2'b11));
        // parallel axes give a zero normal, so every sphere passes the radius test
        set_plane(0, 0, 0, ROTATION_RST, U_AXIS_RST, U_AXIS_RST, 31'h7FFF_FFFF,
                  64'h7FFF_FFFF_7FFF_FFFF);
        send_sphere(make_sphere(32'h7FFF_0000, 32'h1234_5678, 32'h8000_0000, 0, 0,
                                2'b11));
        send_sphere(make_sphere(0, 0, 0, 0, 0, 2'b01));
        // zero quaternion wipes out every axis
        set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 64'd0, U_AXIS_RST,
                  V_AXIS_RST, SIZE_RST, SCALE_RST);
        send_sphere(make_sphere(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 2'b10));
        // negative scales and extreme origin, contact point may wrap
        set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  64'h8000_7FFF_8000_7FFF, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000,
                  31'h7FFF_FFFF, 64'h8000_0000_FFFF_0000);
        for (int i = 0; i < 20; i++)
            send_sphere(make_sphere($urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom));
        set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  64'hFFFF_C000_0000_0000, 48'h0000_0000_C000, 48'h0000_4000_0000,
                  31'd0, 64'h7FFF_FFFF_7FFF_FFFF);
        for (int i = 0; i < 20; i++)
            send_sphere(make_sphere(near_coord(origin_x_r), near_coord(origin_y_r),
                                    near_coord(origin_z_r), $urandom, $urandom,
                                    $urandom));
    endtask

    task automatic test_random_phase(input int items, input int idle_pct,
                                     input int stall_pct);
        random_plane();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++)
            send_sphere(random_sphere());
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        origin_x_r = '0;
        origin_y_r = '0;
        origin_z_r = '0;
        rotation_r = ROTATION_RST;
        u_axis_r = U_AXIS_RST;
        v_axis_r = V_AXIS_RST;
        size_r = SIZE_RST;
        scale_r = SCALE_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_plane();
        test_degenerate_planes();
        test_random_phase(450, 0, 0);
        test_random_phase(450, 60, 0);
        test_random_phase(450, 0, 60);
        test_random_phase(450, 24, 24);
        test_random_phase(50, 0, 0);
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        wait (contact_q.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
rtl/core/spc_pkg.sv
rtl/core/sphere_plane_collision_test.sv
rtl/core/spc_checker.sv
test/tb_top.sv
